/* src/lfse_pkg.sv */
package lfse_pkg;

    // result width before sign extension to 64 bits
    localparam int DATA_WIDTH = 64;
    // datapath width of the shared multiply / divide unit
    localparam int ALU_W = 64;
    localparam int CNT_W = $clog2(ALU_W);

    // y bound used by the x range request
    localparam logic signed [31:0] Y_LIMIT = 32'sd1000000005;

    // request codes
    localparam logic [2:0] MODE_TRI   = 3'd0;
    localparam logic [2:0] MODE_FSUM  = 3'd1;
    localparam logic [2:0] MODE_MSUM  = 3'd2;
    localparam logic [2:0] MODE_RECT  = 3'd3;
    localparam logic [2:0] MODE_RANGE = 3'd4;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RECT,
        S_RECT_M1,
        S_RECT_M2,
        S_RECT_CMP,
        S_RECT_FULL,
        S_RECT_TRI,
        S_RECT_TRI_RET,
        S_RECT_NEXT,
        S_TRI,
        S_TRI_DIV,
        S_TRI_END,
        S_FS_TOP,
        S_FS_ADIV,
        S_FS_APAIR,
        S_FS_AMUL,
        S_FS_BCHK,
        S_FS_BDIV,
        S_FS_BMUL,
        S_FS_TOPMUL,
        S_FS_TOPCHK,
        S_FS_TOPDIV,
        S_FS_DONE,
        S_M12,
        S_M2_GO,
        S_M2_HALF,
        S_M2_BH,
        S_M2_NA,
        S_M2_MF,
        S_OUT
    } t_state;

    // n*(n-1)/2 is formed as pair_x(n) * pair_y(n), dividing the even factor
    function automatic logic [ALU_W-1:0] pair_x(input logic [ALU_W-1:0] n);
        return n[0] ? n : (n >> 1);
    endfunction

    function automatic logic [ALU_W-1:0] pair_y(input logic [ALU_W-1:0] n);
        return n[0] ? ((n - 1'b1) >> 1) : (n - 1'b1);
    endfunction

endpackage

/* src/lfse_if.sv */
interface lfse_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [30:0]        arg_a;
    logic [30:0]        arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
    logic signed [31:0] arg_e;

    modport source (
        output valid, req_type, arg_a, arg_b, arg_c, arg_d, arg_e,
        input  ready
    );
    modport sink (
        input  valid, req_type, arg_a, arg_b, arg_c, arg_d, arg_e,
        output ready
    );
endinterface

interface lfse_res_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result;
    logic               invalid;
    logic               overflow;

    modport source (
        output valid, result, invalid, overflow,
        input  ready
    );
    modport sink (
        input  valid, result, invalid, overflow,
        output ready
    );
endinterface

/* src/lattice_floor_sum_engine.sv */
// Each multiply or divide runs on the shared radix-2 unit; one floor-sum round uses
// up to 7 of them, and a request runs up to six floor sums.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous active-low i_rst_n clears the sequencer and the output beat.
module lattice_floor_sum_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfse_req_if.sink   i_req,
    lfse_res_if.source o_res
);

    localparam int W = lfse_pkg::ALU_W;

    typedef struct packed {
        logic signed [63:0] result;
        logic               invalid;
        logic               overflow;
    } t_res;

    lfse_pkg::t_state     r_state, n_state;
    lfse_pkg::t_state     r_tri_ret, n_tri_ret;
    logic [2:0]           r_mode, n_mode;
    logic [30:0]          r_a, n_a;
    logic [30:0]          r_b, n_b;
    logic signed [31:0]   r_c, n_c;
    logic signed [31:0]   r_d, n_d;
    logic signed [31:0]   r_e, n_e;
    logic                 r_bad, n_bad;
    logic signed [31:0]   r_ra, n_ra;
    logic signed [31:0]   r_rb, n_rb;
    logic                 r_rsel, n_rsel;
    logic                 r_rneg, n_rneg;
    logic [1:0]           r_ti, n_ti;
    logic [W-1:0]         r_tc, n_tc;
    logic                 r_tneg, n_tneg;
    logic [W-1:0]         r_tn, n_tn;
    logic [W-1:0]         r_t1, n_t1;
    logic [W-1:0]         r_t2, n_t2;
    logic [W-1:0]         r_fn, n_fn;
    logic [W-1:0]         r_fm, n_fm;
    logic [W-1:0]         r_fa, n_fa;
    logic [W-1:0]         r_fb, n_fb;
    logic [W-1:0]         r_q, n_q;
    logic [2*W-1:0]       r_acc, n_acc;
    logic [W-1:0]         r_total, n_total;
    logic                 r_ov, n_ov;
    t_res                 r_out, n_out;

    lfse_pkg::t_alu_req   alu_req;
    lfse_pkg::t_alu_rsp   alu_rsp;
    logic [W-1:0]         alu_x;
    logic [W-1:0]         alu_y;
    logic [2*W-1:0]       alu_prod;

    lfse_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_x     (alu_x),
        .i_y     (alu_y),
        .o_rsp   (alu_rsp),
        .o_prod  (alu_prod)
    );

    // sequencer
    always_comb begin
        logic [W-1:0]   term;
        logic [W-1:0]   csx;
        logic [2*W-1:0] val;
        logic [63:0]    res;
        logic           fits;

        n_state   = r_state;
        n_tri_ret = r_tri_ret;
        n_mode    = r_mode;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_e       = r_e;
        n_bad     = r_bad;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_rsel    = r_rsel;
        n_rneg    = r_rneg;
        n_ti      = r_ti;
        n_tc      = r_tc;
        n_tneg    = r_tneg;
        n_tn      = r_tn;
        n_t1      = r_t1;
        n_t2      = r_t2;
        n_fn      = r_fn;
        n_fm      = r_fm;
        n_fa      = r_fa;
        n_fb      = r_fb;
        n_q       = r_q;
        n_acc     = r_acc;
        n_total   = r_total;
        n_out     = r_out;
        n_ov      = r_ov & ~o_res.ready;
        alu_req   = '{start: 1'b0, op: lfse_pkg::ALU_MUL};
        alu_x     = '0;
        alu_y     = '0;

        term = r_acc[W-1:0] + r_tn;
        csx  = W'(r_c);
        if (r_bad) begin
            val = '0;
        end else if (r_mode == lfse_pkg::MODE_FSUM) begin
            val = r_acc;
        end else if (r_mode == lfse_pkg::MODE_MSUM) begin
            val = {{W{1'b0}}, r_total};
        end else begin
            val = {{W{r_total[W-1]}}, r_total};
        end
        res  = 64'($signed(val[lfse_pkg::DATA_WIDTH-1:0]));
        fits = (val[2*W-1:W] == {W{val[W-1]}}) && (res == val[W-1:0]);

        unique case (r_state)
            lfse_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.req_type;
                    n_a     = i_req.arg_a;
                    n_b     = i_req.arg_b;
                    n_c     = i_req.arg_c;
                    n_d     = i_req.arg_d;
                    n_e     = i_req.arg_e;
                    unique case (i_req.req_type) inside
                        lfse_pkg::MODE_TRI, lfse_pkg::MODE_RECT, lfse_pkg::MODE_RANGE: begin
                            n_bad = (i_req.arg_a == '0) || (i_req.arg_b == '0);
                        end
                        lfse_pkg::MODE_FSUM, lfse_pkg::MODE_MSUM: begin
                            n_bad = (i_req.arg_d <= 0) || i_req.arg_c[31];
                        end
                        default: begin
                            n_bad = 1'b1;
                        end
                    endcase
                    n_state = lfse_pkg::S_DISPATCH;
                end
            end

            lfse_pkg::S_DISPATCH: begin
                n_total = '0;
                n_acc   = '0;
                n_rsel  = 1'b0;
                n_rneg  = 1'b0;
                if (r_bad) begin
                    n_state = lfse_pkg::S_OUT;
                end else begin
                    case (r_mode)
                        lfse_pkg::MODE_TRI: begin
                            n_tc      = csx;
                            n_tneg    = 1'b0;
                            n_tri_ret = lfse_pkg::S_OUT;
                            n_state   = lfse_pkg::S_TRI;
                        end
                        lfse_pkg::MODE_RECT: begin
                            n_ra    = r_d;
                            n_rb    = r_e;
                            n_state = lfse_pkg::S_RECT;
                        end
                        lfse_pkg::MODE_RANGE: begin
                            n_ra    = r_e;
                            n_rb    = lfse_pkg::Y_LIMIT;
                            n_state = lfse_pkg::S_RECT;
                        end
                        default: begin
                            n_fn    = {32'd0, r_c};
                            n_fm    = {32'd0, r_d};
                            n_fa    = {33'd0, r_b};
                            n_fb    = {33'd0, r_a};
                            n_state = lfse_pkg::S_FS_TOP;
                        end
                    endcase
                end
            end

            // rectangle clip: full box, or triangle minus two shifted triangles
            lfse_pkg::S_RECT: begin
                if (r_c[31] || (r_ra <= 0) || (r_rb <= 0)) begin
                    n_state = lfse_pkg::S_RECT_NEXT;
                end else begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = {33'd0, r_a};
                    alu_y   = {32'd0, r_ra} - 1'b1;
                    n_state = lfse_pkg::S_RECT_M1;
                end
            end
            lfse_pkg::S_RECT_M1: begin
                if (alu_rsp.done) begin
                    n_t1    = alu_prod[W-1:0];
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = {33'd0, r_b};
                    alu_y   = {32'd0, r_rb} - 1'b1;
                    n_state = lfse_pkg::S_RECT_M2;
                end
            end
            lfse_pkg::S_RECT_M2: begin
                if (alu_rsp.done) begin
                    n_t2    = alu_prod[W-1:0];
                    n_state = lfse_pkg::S_RECT_CMP;
                end
            end
            lfse_pkg::S_RECT_CMP: begin
                if (csx >= (r_t1 + r_t2)) begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = {32'd0, r_ra};
                    alu_y   = {32'd0, r_rb};
                    n_state = lfse_pkg::S_RECT_FULL;
                end else begin
                    n_ti    = '0;
                    n_state = lfse_pkg::S_RECT_TRI;
                end
            end
            lfse_pkg::S_RECT_FULL: begin
                if (alu_rsp.done) begin
                    n_total = r_rneg ? (r_total - alu_prod[W-1:0])
                                     : (r_total + alu_prod[W-1:0]);
                    n_state = lfse_pkg::S_RECT_NEXT;
                end
            end
            lfse_pkg::S_RECT_TRI: begin
                case (r_ti)
                    2'd0: begin
                        n_tc   = csx;
                        n_tneg = r_rneg;
                    end
                    2'd1: begin
                        n_tc   = csx - (r_t1 + {33'd0, r_a});
                        n_tneg = ~r_rneg;
                    end
                    default: begin
                        n_tc   = csx - (r_t2 + {33'd0, r_b});
                        n_tneg = ~r_rneg;
                    end
                endcase
                n_tri_ret = lfse_pkg::S_RECT_TRI_RET;
                n_state   = lfse_pkg::S_TRI;
            end
            lfse_pkg::S_RECT_TRI_RET: begin
                if (r_ti == 2'd2) begin
                    n_state = lfse_pkg::S_RECT_NEXT;
                end else begin
                    n_ti    = r_ti + 1'b1;
                    n_state = lfse_pkg::S_RECT_TRI;
                end
            end
            lfse_pkg::S_RECT_NEXT: begin
                if ((r_mode == lfse_pkg::MODE_RANGE) && !r_rsel) begin
                    n_rsel  = 1'b1;
                    n_rneg  = 1'b1;
                    n_ra    = r_d;
                    n_state = lfse_pkg::S_RECT;
                end else begin
                    n_state = lfse_pkg::S_OUT;
                end
            end

            // triangle count: n = c/a + 1, then floor sum plus n
            lfse_pkg::S_TRI: begin
                if (r_tc[W-1]) begin
                    n_state = r_tri_ret;
                end else begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_DIV};
                    alu_x   = r_tc;
                    alu_y   = {33'd0, r_a};
                    n_state = lfse_pkg::S_TRI_DIV;
                end
            end
            lfse_pkg::S_TRI_DIV: begin
                if (alu_rsp.done) begin
                    n_tn    = alu_prod[W-1:0] + 1'b1;
                    n_fn    = alu_prod[W-1:0] + 1'b1;
                    n_fm    = {33'd0, r_b};
                    n_fa    = {33'd0, r_a};
                    n_fb    = alu_prod[2*W-1:W];
                    n_acc   = '0;
                    n_state = lfse_pkg::S_FS_TOP;
                end
            end
            lfse_pkg::S_TRI_END: begin
                n_total = r_tneg ? (r_total - term) : (r_total + term);
                n_state = r_tri_ret;
            end

            // floor-sum reduction round
            lfse_pkg::S_FS_TOP: begin
                if ((r_fn == '0) || (r_fm == '0)) begin
                    n_state = lfse_pkg::S_FS_DONE;
                end else if (r_fa >= r_fm) begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_DIV};
                    alu_x   = r_fa;
                    alu_y   = r_fm;
                    n_state = lfse_pkg::S_FS_ADIV;
                end else begin
                    n_state = lfse_pkg::S_FS_BCHK;
                end
            end
            lfse_pkg::S_FS_ADIV: begin
                if (alu_rsp.done) begin
                    n_q     = alu_prod[W-1:0];
                    n_fa    = alu_prod[2*W-1:W];
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = lfse_pkg::pair_x(r_fn);
                    alu_y   = lfse_pkg::pair_y(r_fn);
                    n_state = lfse_pkg::S_FS_APAIR;
                end
            end
            lfse_pkg::S_FS_APAIR: begin
                if (alu_rsp.done) begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = alu_prod[W-1:0];
                    alu_y   = r_q;
                    n_state = lfse_pkg::S_FS_AMUL;
                end
            end
            lfse_pkg::S_FS_AMUL: begin
                if (alu_rsp.done) begin
                    n_acc   = r_acc + alu_prod;
                    n_state = lfse_pkg::S_FS_BCHK;
                end
            end
            lfse_pkg::S_FS_BCHK: begin
                if (r_fb >= r_fm) begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_DIV};
                    alu_x   = r_fb;
                    alu_y   = r_fm;
                    n_state = lfse_pkg::S_FS_BDIV;
                end else begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = r_fa;
                    alu_y   = r_fn;
                    n_state = lfse_pkg::S_FS_TOPMUL;
                end
            end
            lfse_pkg::S_FS_BDIV: begin
                if (alu_rsp.done) begin
                    n_fb    = alu_prod[2*W-1:W];
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = r_fn;
                    alu_y   = alu_prod[W-1:0];
                    n_state = lfse_pkg::S_FS_BMUL;
                end
            end
            lfse_pkg::S_FS_BMUL: begin
                if (alu_rsp.done) begin
                    n_acc   = r_acc + alu_prod;
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = r_fa;
                    alu_y   = r_fn;
                    n_state = lfse_pkg::S_FS_TOPMUL;
                end
            end
            lfse_pkg::S_FS_TOPMUL: begin
                if (alu_rsp.done) begin
                    n_q     = alu_prod[W-1:0] + r_fb;
                    n_state = lfse_pkg::S_FS_TOPCHK;
                end
            end
            lfse_pkg::S_FS_TOPCHK: begin
                if (r_q < r_fm) begin
                    n_state = lfse_pkg::S_FS_DONE;
                end else begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_DIV};
                    alu_x   = r_q;
                    alu_y   = r_fm;
                    n_state = lfse_pkg::S_FS_TOPDIV;
                end
            end
            lfse_pkg::S_FS_TOPDIV: begin
                if (alu_rsp.done) begin
                    n_fn    = alu_prod[W-1:0];
                    n_fb    = alu_prod[2*W-1:W];
                    n_fm    = r_fa;
                    n_fa    = r_fm;
                    n_state = lfse_pkg::S_FS_TOP;
                end
            end
            lfse_pkg::S_FS_DONE: begin
                if ((r_mode == lfse_pkg::MODE_FSUM) || (r_mode == lfse_pkg::MODE_MSUM)) begin
                    n_state = lfse_pkg::S_M12;
                end else begin
                    n_state = lfse_pkg::S_TRI_END;
                end
            end

            // remainder sum: n*a + b*n(n-1)/2 - d*floor_sum
            lfse_pkg::S_M12: begin
                if (r_mode == lfse_pkg::MODE_FSUM) begin
                    n_state = lfse_pkg::S_OUT;
                end else begin
                    n_fn    = {32'd0, r_c};
                    n_state = lfse_pkg::S_M2_GO;
                end
            end
            lfse_pkg::S_M2_GO: begin
                alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                alu_x   = lfse_pkg::pair_x(r_fn);
                alu_y   = lfse_pkg::pair_y(r_fn);
                n_state = lfse_pkg::S_M2_HALF;
            end
            lfse_pkg::S_M2_HALF: begin
                if (alu_rsp.done) begin
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = alu_prod[W-1:0];
                    alu_y   = {33'd0, r_b};
                    n_state = lfse_pkg::S_M2_BH;
                end
            end
            lfse_pkg::S_M2_BH: begin
                if (alu_rsp.done) begin
                    n_total = alu_prod[W-1:0];
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = {32'd0, r_c};
                    alu_y   = {33'd0, r_a};
                    n_state = lfse_pkg::S_M2_NA;
                end
            end
            lfse_pkg::S_M2_NA: begin
                if (alu_rsp.done) begin
                    n_total = r_total + alu_prod[W-1:0];
                    alu_req = '{start: 1'b1, op: lfse_pkg::ALU_MUL};
                    alu_x   = {32'd0, r_d};
                    alu_y   = r_acc[W-1:0];
                    n_state = lfse_pkg::S_M2_MF;
                end
            end
            lfse_pkg::S_M2_MF: begin
                if (alu_rsp.done) begin
                    n_total = r_total - alu_prod[W-1:0];
                    n_state = lfse_pkg::S_OUT;
                end
            end

            // hand the result to the output register once it is free
            lfse_pkg::S_OUT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov           = 1'b1;
                    n_out.result   = res;
                    n_out.invalid  = r_bad;
                    n_out.overflow = ~fits;
                    n_state        = lfse_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lfse_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfse_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_tri_ret <= n_tri_ret;
        r_mode    <= n_mode;
        r_a       <= n_a;
        r_b       <= n_b;
        r_c       <= n_c;
        r_d       <= n_d;
        r_e       <= n_e;
        r_bad     <= n_bad;
        r_ra      <= n_ra;
        r_rb      <= n_rb;
        r_rsel    <= n_rsel;
        r_rneg    <= n_rneg;
        r_ti      <= n_ti;
        r_tc      <= n_tc;
        r_tneg    <= n_tneg;
        r_tn      <= n_tn;
        r_t1      <= n_t1;
        r_t2      <= n_t2;
        r_fn      <= n_fn;
        r_fm      <= n_fm;
        r_fa      <= n_fa;
        r_fb      <= n_fb;
        r_q       <= n_q;
        r_acc     <= n_acc;
        r_total   <= n_total;
        r_out     <= n_out;
    end

    assign i_req.ready    = (r_state == lfse_pkg::S_IDLE);
    assign o_res.valid    = r_ov;
    assign o_res.result   = r_out.result;
    assign o_res.invalid  = r_out.invalid;
    assign o_res.overflow = r_out.overflow;

    // shared unit is only started when free
    a_alu_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("shared unit started while busy");

    // an invalid request yields a zero result with no overflow
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.invalid) |-> ((r_out.result == '0) && !r_out.overflow))
        else $error("invalid request gave nonzero result");

    // an accepted beat starts the sequencer
    a_accept_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == lfse_pkg::S_DISPATCH))
        else $error("accepted beat did not start work");

endmodule

/* src/lfse_alu.sv */
module lfse_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfse_pkg::t_alu_req            i_req,
    input  logic [lfse_pkg::ALU_W-1:0]    i_x,
    input  logic [lfse_pkg::ALU_W-1:0]    i_y,
    output lfse_pkg::t_alu_rsp            o_rsp,
    output logic [2*lfse_pkg::ALU_W-1:0]  o_prod
);

    localparam int W = lfse_pkg::ALU_W;

    logic                         r_busy;
    logic                         r_done;
    logic [lfse_pkg::CNT_W-1:0]   r_cnt;
    lfse_pkg::t_alu_op            r_op;
    logic [W-1:0]                 r_y;
    logic [2*W-1:0]               r_p;
    logic [2*W-1:0]               n_p;

    logic [W:0] mul_sum;
    logic [W:0] div_top;
    logic [W:0] div_diff;
    logic       div_ge;

    // one radix-2 step: shift-add for multiply, restoring step for divide
    always_comb begin
        mul_sum  = {1'b0, r_p[2*W-1:W]} + (r_p[0] ? {1'b0, r_y} : '0);
        div_top  = r_p[2*W-1:W-1];
        div_diff = div_top - {1'b0, r_y};
        div_ge   = ~div_diff[W];
        if (r_op == lfse_pkg::ALU_MUL) begin
            n_p = {mul_sum, r_p[W-1:1]};
        end else begin
            n_p = {(div_ge ? div_diff[W-1:0] : div_top[W-1:0]), r_p[W-2:0], div_ge};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lfse_pkg::CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial result
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op <= i_req.op;
            r_y  <= i_y;
            r_p  <= {{W{1'b0}}, i_x};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    // product, or remainder in the upper half and quotient in the lower half
    assign o_prod     = r_p;

endmodule
